/* design/rtcdv_pkg.sv */
// package for the rtc date validator: request types, status codes, calendar helpers
`timescale 1ns / 1ps
`default_nettype none

package rtcdv_pkg;

  // status codes of a result
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusRange    = 2'd1;
  localparam logic [1:0] StatusDayLimit = 2'd2;

  // offset so that 2000-01-01 lands on saturday, minus one for the day count
  localparam logic [7:0] WeekdayBias = 8'd5;

  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day_of_month;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [2:0] weekday_bcd;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
  } out_item_t;

  // days in a month, february without the leap day
  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] len;
    case (mo)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // cumulative days before the month, reduced mod 7
  function automatic logic [2:0] days_before_mod7(input logic [3:0] mo);
    logic [2:0] r;
    case (mo)
      4'd1:    r = 3'd0;  // 0
      4'd2:    r = 3'd3;  // 31
      4'd3:    r = 3'd3;  // 59
      4'd4:    r = 3'd6;  // 90
      4'd5:    r = 3'd1;  // 120
      4'd6:    r = 3'd4;  // 151
      4'd7:    r = 3'd6;  // 181
      4'd8:    r = 3'd2;  // 212
      4'd9:    r = 3'd5;  // 243
      4'd10:   r = 3'd0;  // 273
      4'd11:   r = 3'd3;  // 304
      4'd12:   r = 3'd5;  // 334
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // 8-bit value mod 7 by folding: 64 and 8 are both 1 mod 7
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [6:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    logic [3:0] f4;
    f1 = {5'b0, x[7:6]} + {1'b0, x[5:0]};
    f2 = f1[6:3] + {1'b0, f1[2:0]};
    f3 = {3'b0, f2[3]} + {1'b0, f2[2:0]};
    f4 = (f3 >= 4'd7) ? (f3 - 4'd7) : f3;
    return f4[2:0];
  endfunction

  // packed bcd of a value below 100, tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    prod   = {8'b0, v} * 15'd205;
    tens   = prod[14:11];
    tens10 = {tens, 3'b0} + {2'b0, tens, 1'b0};
    ones   = v - tens10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

/* design/rtc_date_validate_bcd_encode.sv */
// top level: input register, date check and encode, result register
// an accepted request waits in the input register, then is checked, encoded and captured in the result register
// throughput: one request per cycle; the input and result registers each move on
//   whenever the stage after them is free, so stalls back up one stage at a time
// reset: rst is synchronous, active high, and clears both stage valid flags
`timescale 1ns / 1ps
`default_nettype none

module rtc_date_validate_bcd_encode import rtcdv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t result;
  logic      s1_free;
  logic      s2_free;

  // stage flow
  assign s2_free  = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item <= in_data;
    end
  end

  // check and encode
  rtcdv_encode u_encode (
    .item   (s1_item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      out_data <= result;
    end
  end

  // error results carry no bcd bytes
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != StatusOk)) |->
      ((out_data.second_bcd == '0) && (out_data.minute_bcd == '0) &&
       (out_data.hour_bcd == '0) && (out_data.weekday_bcd == '0) &&
       (out_data.day_bcd == '0) && (out_data.month_bcd == '0) &&
       (out_data.year_bcd == '0)))
    else $error("error result with nonzero bcd bytes");

  // only defined status codes and weekdays leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.status == StatusOk) || (out_data.status == StatusRange) ||
                   (out_data.status == StatusDayLimit)) && (out_data.weekday_bcd <= 3'd6))
    else $error("bad status or weekday");

  // a held request in the input register is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_free) |=> (s1_valid && $stable(s1_item)))
    else $error("input stage lost a request");

  // an accepted request lands in the input register
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted request not captured");

  // a request in the input register with a free result stage moves on
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_free) |=> out_valid)
    else $error("request did not reach the result register");

endmodule

`default_nettype wire

/* design/rtcdv_encode.sv */
// range check, month length check, weekday and bcd encoding of one request
`timescale 1ns / 1ps
`default_nettype none

module rtcdv_encode import rtcdv_pkg::*; (
  input  in_item_t  item,
  output out_item_t result
);

  logic       range_err;
  logic       day_err;
  logic       leap;
  logic [4:0] mlen;
  logic [7:0] year_q;
  logic [7:0] wd_sum;
  logic [2:0] weekday;
  logic [7:0] se_bcd;
  logic [7:0] mi_bcd;
  logic [7:0] hr_bcd;
  logic [7:0] dy_bcd;
  logic [7:0] mo_bcd;
  logic [7:0] yr_bcd;

  // field ranges
  assign range_err = (item.second > 8'd59) || (item.minute > 8'd59) ||
                     (item.hour > 8'd23) || (item.day_of_month == 8'd0) ||
                     (item.day_of_month > 8'd31) || (item.month == 8'd0) ||
                     (item.month > 8'd12) || (item.year > 8'd99);

  // day against month length, leap february allows the 29th
  assign leap    = (item.year[1:0] == 2'b00);
  assign mlen    = month_len(item.month[3:0]);
  assign day_err = !((item.month == 8'd2) && leap && (item.day_of_month == 8'd29)) &&
                   (item.day_of_month > {3'b0, mlen});

  // weekday: 365 is 1 mod 7, so the year term reduces to the year itself
  assign year_q  = ({1'b0, item.year[6:0]} + 8'd3) >> 2;
  assign wd_sum  = {3'b0, item.day_of_month[4:0]}
                 + {5'b0, days_before_mod7(item.month[3:0])}
                 + {7'b0, (item.month > 8'd2) && leap}
                 + {1'b0, item.year[6:0]}
                 + year_q
                 + WeekdayBias;
  assign weekday = mod7(wd_sum);

  // bcd of each field
  assign se_bcd = to_bcd(item.second[6:0]);
  assign mi_bcd = to_bcd(item.minute[6:0]);
  assign hr_bcd = to_bcd(item.hour[6:0]);
  assign dy_bcd = to_bcd(item.day_of_month[6:0]);
  assign mo_bcd = to_bcd(item.month[6:0]);
  assign yr_bcd = to_bcd(item.year[6:0]);

  // result: status code, with every bcd field zero on error
  always_comb begin
    result = '0;
    if (range_err) begin
      result.status = StatusRange;
    end else if (day_err) begin
      result.status = StatusDayLimit;
    end else begin
      result.status      = StatusOk;
      result.second_bcd  = se_bcd[6:0];
      result.minute_bcd  = mi_bcd[6:0];
      result.hour_bcd    = hr_bcd[5:0];
      result.weekday_bcd = weekday;
      result.day_bcd     = dy_bcd[5:0];
      result.month_bcd   = mo_bcd[4:0];
      result.year_bcd    = yr_bcd;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// testbench for rtc_date_validate_bcd_encode: range and month-length checks, weekday, bcd bytes
module tb_top;
  import rtcdv_pkg::*;

  localparam int IdlePct     = 29;
  localparam int HoldCycles  = 150;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int ReportMax   = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predicted clock register sets, oldest first
  out_item_t pending_regs_q[$];

  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit hold_armed = 1'b0;
  int hold_left  = 0;

  int sent_count     = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int ok_dates       = 0;
  int range_errors   = 0;
  int daylimit_hits  = 0;
  int quiet_cycles   = 0;

  rtc_date_validate_bcd_encode dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // calendar month length, february grows in leap years
  function automatic int unsigned month_days(input int unsigned mo, input bit leap_year);
    int unsigned len;
    case (mo)
      2:             len = leap_year ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // two decimal digits packed into one byte
  function automatic logic [7:0] bcd_of(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // expected status and register bytes for one date
  function automatic out_item_t rtc_regs_of(input in_item_t d);
    out_item_t   r;
    bit          leap_year;
    int unsigned days;
    int unsigned mo;
    r = '0;
    if (d.second > 59 || d.minute > 59 || d.hour > 23 || d.day_of_month == 0 ||
        d.day_of_month > 31 || d.month == 0 || d.month > 12 || d.year > 99) begin
      r.status = StatusRange;
      return r;
    end
    leap_year = (d.year % 4) == 0;
    if (d.day_of_month > month_days(d.month, leap_year)) begin
      r.status = StatusDayLimit;
      return r;
    end
    // days elapsed since 2000-01-01, a saturday
    days = d.day_of_month - 1 + 365 * d.year + (d.year + 3) / 4;
    for (mo = 1; mo < d.month; mo++) days += month_days(mo, leap_year);
    r.status      = StatusOk;
    r.weekday_bcd = 3'((days + 6) % 7);
    r.second_bcd  = 7'(bcd_of(d.second));
    r.minute_bcd  = 7'(bcd_of(d.minute));
    r.hour_bcd    = 6'(bcd_of(d.hour));
    r.day_bcd     = 6'(bcd_of(d.day_of_month));
    r.month_bcd   = 5'(bcd_of(d.month));
    r.year_bcd    = bcd_of(d.year);
    return r;
  endfunction

  // offer one request until it is taken, then record its prediction
  task automatic send_request(input in_item_t req);
    out_item_t want;
    want = rtc_regs_of(req);
    @(negedge clk);
    while (tx_gaps_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_regs_q.push_back(want);
    sent_count++;
    case (want.status)
      StatusOk:       ok_dates++;
      StatusRange:    range_errors++;
      default:        daylimit_hits++;
    endcase
  endtask

  task automatic send_date(input int y, input int mo, input int dy,
                           input int h, input int mi, input int s);
    in_item_t d;
    d.year         = 8'(y);
    d.month        = 8'(mo);
    d.day_of_month = 8'(dy);
    d.hour         = 8'(h);
    d.minute       = 8'(mi);
    d.second       = 8'(s);
    send_request(d);
  endtask

  // well-formed date, or one with the day near the end of the month
  function automatic in_item_t random_date(input bit edge_day);
    in_item_t    d;
    int unsigned len;
    d.year         = 8'($urandom_range(99));
    d.month        = 8'($urandom_range(1, 12));
    len            = month_days(d.month, (d.year % 4) == 0);
    d.day_of_month = edge_day ? 8'($urandom_range(28, 31)) : 8'($urandom_range(1, len));
    d.hour         = 8'($urandom_range(23));
    d.minute       = 8'($urandom_range(59));
    d.second       = 8'($urandom_range(59));
    return d;
  endfunction

  // mix of good dates, month-end probes, one bad field and full noise
  function automatic in_item_t random_request();
    in_item_t    d;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      d = random_date(1'b0);
    end else if (pick < 82) begin
      d = random_date(1'b1);
    end else if (pick < 92) begin
      d = random_date(1'b0);
      case ($urandom_range(5))
        0:       d.year         = 8'($urandom_range(255));
        1:       d.month        = 8'($urandom_range(255));
        2:       d.day_of_month = 8'($urandom_range(255));
        3:       d.hour         = 8'($urandom_range(255));
        4:       d.minute       = 8'($urandom_range(255));
        default: d.second       = 8'($urandom_range(255));
      endcase
    end else begin
      d.year         = 8'($urandom_range(255));
      d.month        = 8'($urandom_range(255));
      d.day_of_month = 8'($urandom_range(255));
      d.hour         = 8'($urandom_range(255));
      d.minute       = 8'($urandom_range(255));
      d.second       = 8'($urandom_range(255));
    end
    return d;
  endfunction

  // century ends, leap february, month ends and each out-of-range field
  task automatic test_calendar_corners();
    send_date(0, 1, 1, 0, 0, 0);
    send_date(99, 12, 31, 23, 59, 59);
    send_date(0, 2, 29, 12, 30, 45);
    send_date(4, 2, 29, 1, 2, 3);
    send_date(1, 2, 29, 1, 2, 3);
    send_date(4, 2, 30, 1, 2, 3);
    send_date(3, 2, 28, 9, 9, 9);
    send_date(5, 4, 31, 10, 10, 10);
    send_date(5, 4, 30, 10, 10, 10);
    send_date(7, 3, 1, 0, 0, 0);
    send_date(8, 3, 1, 0, 0, 0);
    send_date(0, 12, 31, 23, 59, 59);
    send_date(10, 5, 5, 0, 0, 60);
    send_date(10, 5, 5, 0, 60, 0);
    send_date(10, 5, 5, 24, 0, 0);
    send_date(10, 5, 0, 0, 0, 0);
    send_date(10, 5, 32, 0, 0, 0);
    send_date(10, 0, 5, 0, 0, 0);
    send_date(10, 13, 5, 0, 0, 0);
    send_date(100, 5, 5, 0, 0, 0);
    send_date(255, 255, 255, 255, 255, 255);
    send_date(0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) send_request(random_request());
  endtask

  // no gaps on either side
  task automatic test_back_to_back(input int count);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (count) send_request(random_request());
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_holdoff(input int count);
    tx_gaps_on = 1'b0;
    hold_armed = 1'b1;
    repeat (count) send_request(random_request());
    tx_gaps_on = 1'b1;
  endtask

  // receiver side: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_left  = HoldCycles;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_gaps_on && ($urandom_range(99) < IdlePct);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      checked_count++;
      if (pending_regs_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportMax)
          $display("%0t: result with no request pending, status %0d", $time,
                   out_data.status);
      end else begin
        want = pending_regs_q.pop_front();
        if (out_data.status !== want.status || out_data.second_bcd !== want.second_bcd ||
            out_data.minute_bcd !== want.minute_bcd || out_data.hour_bcd !== want.hour_bcd ||
            out_data.weekday_bcd !== want.weekday_bcd || out_data.day_bcd !== want.day_bcd ||
            out_data.month_bcd !== want.month_bcd || out_data.year_bcd !== want.year_bcd) begin
          error_count++;
          if (error_count <= ReportMax)
            $display({"%0t: mismatch expected st=%0d s=%h m=%h h=%h wd=%0d d=%h mo=%h y=%h",
                      " got st=%0d s=%h m=%h h=%h wd=%0d d=%h mo=%h y=%h"}, $time,
                     want.status, want.second_bcd, want.minute_bcd, want.hour_bcd,
                     want.weekday_bcd, want.day_bcd, want.month_bcd, want.year_bcd,
                     out_data.status, out_data.second_bcd, out_data.minute_bcd,
                     out_data.hour_bcd, out_data.weekday_bcd, out_data.day_bcd,
                     out_data.month_bcd, out_data.year_bcd);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: %0d cycles without progress, %0d results pending",
                 quiet_cycles, pending_regs_q.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_calendar_corners();
    test_random_dates(600);
    test_back_to_back(300);
    test_output_holdoff(40);
    test_random_dates(590);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_regs_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d dates: %0d valid, %0d with a field out of range, %0d past month end",
             sent_count, ok_dates, range_errors, daylimit_hits);
    $display("checked %0d results with gaps, back-to-back traffic and a long output hold-off",
             checked_count);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d failures", error_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
